### src/soft_clip_foldback_distortion_macros.svh
// assertion macros shared by the distortion block
`ifndef SOFT_CLIP_FOLDBACK_DISTORTION_MACROS_SVH
`define SOFT_CLIP_FOLDBACK_DISTORTION_MACROS_SVH

// clocked assertion, quiet while reset is high
`define SCFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication form built on the one above
`define SCFD_ASSERT_IMP(label, cond, expr, msg) \
  `SCFD_ASSERT(label, (cond) |-> (expr), msg)

`endif

### src/scfd_pkg.sv
package scfd_pkg;

  // sample format
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int THR_BITS    = FRAC_BITS;

  // remainder unit works on the dividend with its two low bits split off
  localparam int DIV_STEPS  = FRAC_BITS - 2;
  // input, square, series, halve, fold test, divider, fold arithmetic, output
  localparam int NUM_STAGES = DIV_STEPS + 7;

  // register file
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic REG_FOLD_THRESHOLD = 1'b0;

  // threshold after reset: 0.125
  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1) << (FRAC_BITS - 3);

  // rounding bias for x*x
  localparam logic [2*SAMPLE_BITS-1:0] ROUND_Q = (2*SAMPLE_BITS)'(1) << (FRAC_BITS - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

### src/soft_clip_foldback_distortion.sv
// channel   direction  handshake                   payload
// sample    in         sample_valid / sample_stall sample_in
// result    out        result_valid / result_stall sample_out, folded
// config    in         apb (psel, penable, pwrite) fold_threshold at byte 0
//
// one request per cycle while sample_stall is low
// the remainder for the fold is a restoring divider, one quotient bit a stage
// reset is synchronous, clears valid bits and sets the threshold register to THR_RESET
// a stall on the result side holds the last stage; earlier stages keep
// moving until they fill, so empty slots close up before input is stalled
module soft_clip_foldback_distortion
  import scfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample_in,
  output logic                 result_valid,
  input  logic                 result_stall,
  output sample_t              sample_out,
  output logic                 folded
);

  `include "soft_clip_foldback_distortion_macros.svh"

  localparam int W = SAMPLE_BITS;
  localparam int F = FRAC_BITS;

  // configuration register
  logic [THR_BITS-1:0] fold_threshold;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_threshold <= THR_RESET;
    end else if (cfg_write && paddr[2] == REG_FOLD_THRESHOLD) begin
      fold_threshold <= pwdata[THR_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FOLD_THRESHOLD) begin
      prdata = DATA_BITS'(fold_threshold);
    end
  end

  // stage enables: a stage holds only when it and every later stage are full
  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] en;
  logic                  accept;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_en
    assign en[i] = !result_stall || !(&v[NUM_STAGES-1:i]);
  end

  assign sample_stall = !en[0];
  assign accept       = sample_valid && en[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? accept : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // stage 1: input register
  sample_t x1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1 <= sample_in;
    end
  end

  // stage 2: square of the magnitude
  sample_t           x2;
  logic [W-1:0]      mag1;
  logic [2*W-1:0]    q2;

  assign mag1 = x1[W-1] ? (~x1 + W'(1)) : x1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x2 <= x1;
      q2 <= mag1 * mag1;
    end
  end

  // stage 3: x -/+ x*x with round half up
  logic [2*W-1:0]     q_rnd;
  logic [W-1:0]       t2;
  logic signed [W:0]  s2;
  logic signed [W:0]  s3;

  assign q_rnd = q2 + ROUND_Q;
  assign t2    = q_rnd[F +: W];

  always_comb begin
    if (x2 > 0) begin
      s2 = $signed({x2[W-1], x2}) - $signed({1'b0, t2});
    end else begin
      s2 = $signed({x2[W-1], x2}) + $signed({1'b0, t2});
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3 <= s2;
    end
  end

  // stage 4: halve, round half up
  logic signed [W:0] s3_inc;
  sample_t           y4;

  assign s3_inc = s3 + (W+1)'(1);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      y4 <= s3_inc[W:1];
    end
  end

  // stage 5: threshold test and dividend for the fold
  // |y-T| mod 4T is 4*((|y-T|>>2) mod T) plus the two low bits
  logic signed [W:0]     y4_x;
  logic signed [W:0]     thr_x;
  logic signed [W:0]     d4;
  logic [W:0]            dmag4;
  logic                  fold4;

  logic [THR_BITS-1:0]   dv_rem  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]  dv_dvd  [DIV_STEPS+1];
  sample_t               dv_y    [DIV_STEPS+1];
  logic                  dv_fold [DIV_STEPS+1];
  logic [1:0]            dv_low  [DIV_STEPS+1];

  assign y4_x  = {y4[W-1], y4};
  assign thr_x = $signed({2'b00, fold_threshold});
  assign fold4 = (y4_x > thr_x) || (y4_x < -thr_x);
  assign d4    = y4_x - thr_x;
  assign dmag4 = d4[W] ? (~d4 + (W+1)'(1)) : d4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      dv_rem[0]  <= '0;
      dv_dvd[0]  <= dmag4[DIV_STEPS+1:2];
      dv_low[0]  <= dmag4[1:0];
      dv_y[0]    <= y4;
      dv_fold[0] <= fold4;
    end
  end

  // restoring divider for the remainder, one dividend bit a stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [THR_BITS:0]   trial;
    logic [THR_BITS:0]   trial_sub;
    logic                take;

    assign trial     = {dv_rem[k], dv_dvd[k][DIV_STEPS-1]};
    assign trial_sub = trial - {1'b0, fold_threshold};
    assign take      = trial >= {1'b0, fold_threshold};

    always_ff @(posedge clk) begin
      if (en[5+k]) begin
        dv_rem[k+1]  <= take ? trial_sub[THR_BITS-1:0] : trial[THR_BITS-1:0];
        dv_dvd[k+1]  <= {dv_dvd[k][DIV_STEPS-2:0], 1'b0};
        dv_low[k+1]  <= dv_low[k];
        dv_y[k+1]    <= dv_y[k];
        dv_fold[k+1] <= dv_fold[k];
      end
    end
  end

  // fold arithmetic: e = |a - 2T|
  localparam int PS = DIV_STEPS + 5;

  logic [F+1:0]        fa;
  logic signed [F+2:0] fdiff;
  logic [F+2:0]        fabs;
  logic [F:0]          e6;
  sample_t             y6;
  logic                fold6;

  assign fa    = {dv_rem[DIV_STEPS], dv_low[DIV_STEPS]};
  assign fdiff = $signed({1'b0, fa}) - $signed({2'b00, fold_threshold, 1'b0});
  assign fabs  = fdiff[F+2] ? (~fdiff + (F+3)'(1)) : fdiff;

  always_ff @(posedge clk) begin
    if (en[PS]) begin
      e6    <= fabs[F:0];
      y6    <= dv_y[DIV_STEPS];
      fold6 <= dv_fold[DIV_STEPS];
    end
  end

  // output register: the clipped value when not folded, else e - T, or zero for a zero threshold
  logic signed [W:0] eo6;

  assign eo6 = $signed({1'b0, e6}) - $signed({2'b00, fold_threshold});

  always_ff @(posedge clk) begin
    if (en[PS+1]) begin
      folded <= fold6;
      if (!fold6) begin
        sample_out <= y6;
      end else if (fold_threshold == '0) begin
        sample_out <= '0;
      end else begin
        sample_out <= eo6[W-1:0];
      end
    end
  end

  assign result_valid = v[NUM_STAGES-1];

  // checks
  logic signed [W:0] out_x;

  assign out_x = {sample_out[W-1], sample_out};

  `SCFD_ASSERT_IMP(a_out_in_band, result_valid,
                   (out_x <= thr_x) && (out_x >= -thr_x), "result outside threshold band")
  `SCFD_ASSERT_IMP(a_stall_cause, sample_stall,
                   result_valid && result_stall, "input stalled without output back pressure")
  `SCFD_ASSERT_IMP(a_valid_source, $rose(result_valid),
                   $past(v[NUM_STAGES-2]), "result valid without a request behind it")
  `SCFD_ASSERT_IMP(a_hold_full, result_valid && result_stall && (&v),
                   sample_stall, "full pipe took a request under back pressure")

endmodule

### verif/soft_clip_foldback_distortion_tb.sv
module soft_clip_foldback_distortion_tb
  import scfd_pkg::*;
();

  // register map: the threshold at index 0, index 1 lies beyond the register file
  localparam int REG_SPARE = 1;
  localparam logic [ADDR_BITS-1:0] THR_ADDR   = ADDR_BITS'(4 * REG_FOLD_THRESHOLD);
  localparam logic [ADDR_BITS-1:0] SPARE_ADDR = ADDR_BITS'(4 * REG_SPARE);
  localparam logic [THR_BITS-1:0]  THR_MAX    = {THR_BITS{1'b1}};
  // 0.25 in sample lsbs, above any positive soft-clip output
  localparam int QUARTER_SCALE = 1 << (FRAC_BITS - 2);
  localparam int MAX_REPORTS   = 40;
  localparam int DRAIN_LIMIT   = 100000;

  typedef struct packed {
    sample_t value;
    logic    folded;
  } distorted_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 sample_valid;
  logic                 sample_stall;
  sample_t              sample_in;
  logic                 result_valid;
  logic                 result_stall;
  sample_t              sample_out;
  logic                 folded;

  // threshold as the block should hold it
  logic [THR_BITS-1:0] fold_thr;
  distorted_t          pending_outputs[$];
  int unsigned         errors;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  int unsigned         hold_left;

  soft_clip_foldback_distortion dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .folded       (folded)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // soft clip then foldback, exact integer arithmetic
  function automatic distorted_t distort_sample(sample_t x, logic [THR_BITS-1:0] thr_bits);
    longint xs;
    longint mag;
    longint half_sq;
    longint ser;
    longint y;
    longint thr;
    longint d;
    longint rem;
    longint e;
    distorted_t r;
    xs = x;
    mag = (xs < 0) ? -xs : xs;
    half_sq = (mag * mag + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    ser = (xs > 0) ? xs - half_sq : xs + half_sq;
    y = (ser + 1) >>> 1;
    thr = longint'(thr_bits);
    r.folded = (y > thr) || (y < -thr);
    if (r.folded) begin
      if (thr == 0) begin
        y = 0;
      end else begin
        d = y - thr;
        if (d < 0) d = -d;
        rem = d % (4 * thr);
        e = rem - 2 * thr;
        if (e < 0) e = -e;
        y = e - thr;
      end
    end
    r.value = sample_t'(y);
    return r;
  endfunction

  // receiver stall: long hold-off when requested, else random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker
  task automatic compare_result();
    distorted_t want;
    if (pending_outputs.size() == 0) begin
      if (errors < MAX_REPORTS)
        $display("%0t: unexpected result sample_out=%0d folded=%0b",
                 $time, sample_out, folded);
      errors++;
    end else begin
      want = pending_outputs.pop_front();
      if (sample_out !== want.value) begin
        if (errors < MAX_REPORTS)
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, want.value, sample_out);
        errors++;
      end
      if (folded !== want.folded) begin
        if (errors < MAX_REPORTS)
          $display("%0t: folded mismatch, expected %0b, got %0b",
                   $time, want.folded, folded);
        errors++;
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) compare_result();
    end
  end

  // one request on the sample channel, with random idle cycles ahead of it
  task automatic send_sample(input sample_t x);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      sample_in <= sample_t'($urandom);
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (sample_stall);
    pending_outputs.push_back(distort_sample(x, fold_thr));
  endtask

  // stop offering, wait for every result and the pipeline to empty
  task automatic drain();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == THR_ADDR) fold_thr = data[THR_BITS-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // read the threshold back and compare
  task automatic check_threshold();
    logic [DATA_BITS-1:0] want;
    want = DATA_BITS'(fold_thr);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= THR_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      if (errors < MAX_REPORTS)
        $display("%0t: threshold readback mismatch, expected %0d, got %0d",
                 $time, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_threshold(input logic [DATA_BITS-1:0] data);
    drain();
    apb_write(THR_ADDR, data);
    check_threshold();
  endtask

  // mostly thresholds that fold, some tiny, some zero, some at 0.25 or above
  function automatic logic [DATA_BITS-1:0] pick_threshold();
    logic [THR_BITS-1:0] thr;
    case ($urandom_range(9))
      0: thr = '0;
      1: thr = THR_BITS'($urandom_range(1, 64));
      2: thr = THR_BITS'($urandom_range(QUARTER_SCALE, int'(THR_MAX)));
      default: thr = THR_BITS'($urandom_range(1, QUARTER_SCALE - 1));
    endcase
    return ($urandom & ~DATA_BITS'(THR_MAX)) | DATA_BITS'(thr);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom);
      1: return sample_t'($signed($urandom) >>> $urandom_range(1, 20));
      2: return sample_t'($signed($urandom) >>> 8);
      default: return $urandom_range(1) ? sample_t'({1'b0, {FRAC_BITS{1'b1}}} - $urandom_range(255))
                                        : sample_t'({1'b1, {FRAC_BITS{1'b0}}} + $urandom_range(255));
    endcase
  endfunction

  // threshold after reset and small, half-scale and extreme samples under it
  task automatic test_reset_state();
    sample_t picks[8];
    picks = '{sample_t'(0), sample_t'(1), sample_t'(-1), sample_t'(2),
              sample_t'(8388607), sample_t'(-8388608), sample_t'(4194304),
              sample_t'(-4194304)};
    check_threshold();
    foreach (picks[i]) send_sample(picks[i]);
  endtask

  // zero, smallest, just below and at 0.25, and the widest threshold
  task automatic test_threshold_extremes();
    logic [DATA_BITS-1:0] thrs[5];
    sample_t picks[3];
    thrs = '{DATA_BITS'(0), DATA_BITS'(1), DATA_BITS'(QUARTER_SCALE - 1),
             DATA_BITS'(QUARTER_SCALE), {DATA_BITS{1'b1}}};
    picks = '{sample_t'(8388607), sample_t'(-8388608), sample_t'(-1)};
    foreach (thrs[i]) begin
      set_threshold(thrs[i]);
      foreach (picks[j]) send_sample(picks[j]);
    end
  endtask

  // write beyond the register file must leave the threshold alone
  task automatic test_spare_address();
    set_threshold(DATA_BITS'(THR_RESET));
    apb_write(SPARE_ADDR, 32'h0000_0003);
    check_threshold();
    send_sample(sample_t'(3000000));
    send_sample(sample_t'(-3000000));
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned blocks);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (blocks) begin
      set_threshold(pick_threshold());
      repeat (59) send_sample(pick_sample());
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_output_backpressure();
    set_threshold(pick_threshold());
    @(posedge clk);
    hold_left = 3 * NUM_STAGES + 100;
    repeat (80) send_sample(pick_sample());
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_sender_pause();
    repeat (20) send_sample(pick_sample());
    drain();
    repeat (20) send_sample(pick_sample());
  endtask

  task automatic finish_run();
    drain();
    if (pending_outputs.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_outputs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_valid = 1'b0;
    sample_in = '0;
    result_stall = 1'b0;
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 0;
    fold_thr = THR_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 19;
    recv_idle_pct = 50;
    test_reset_state();
    test_threshold_extremes();
    test_spare_address();
    test_random_traffic(19, 50, 4);
    test_random_traffic(50, 19, 4);
    test_random_traffic(0, 0, 4);
    test_output_backpressure();
    test_sender_pause();
    finish_run();
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### soft_clip_foldback_distortion.f
+incdir+src
src/scfd_pkg.sv
src/soft_clip_foldback_distortion.sv
verif/soft_clip_foldback_distortion_tb.sv
